@@ sv/fkt_pkg.sv @@
// ----------------------------------------------------------------------------
// fkt_pkg: shared definitions for the free-list keyed table
// Default sizes, operation codes, result status codes and the sentinel word.
// ----------------------------------------------------------------------------
package fkt_pkg;

  localparam int unsigned FKT_DEPTH     = 64;
  localparam int unsigned FKT_KEY_BYTES = 8;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd1;
  localparam logic [2:0] ST_FULL         = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX    = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd4;

  localparam logic [31:0] SENTINEL_WORD = 32'hFFFF_FFFF;

endpackage

@@ sv/fkt_key_norm.sv @@
// ----------------------------------------------------------------------------
// fkt_key_norm: name key normalization
// Keeps the low KEY_BYTES bytes of the key and clears every byte after the
// first zero byte, the first byte being the most significant one.
// ----------------------------------------------------------------------------
module fkt_key_norm #(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic [63:0]          key_i,
  output logic [8*KEY_BYTES-1:0] key_o
);

  always_comb begin
    logic       ended;
    logic [7:0] b;
    ended = 1'b0;
    b     = '0;
    key_o = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = key_i[8*(KEY_BYTES-1-i) +: 8];
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      key_o[8*(KEY_BYTES-1-i) +: 8] = ended ? 8'd0 : b;
    end
  end

endmodule

@@ sv/fkt_slot_mem.sv @@
// ----------------------------------------------------------------------------
// fkt_slot_mem: slot storage
// Key and word arrays with one write port and one registered read port.
// ----------------------------------------------------------------------------
module fkt_slot_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned KW    = 64,
  localparam int unsigned IW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [KW-1:0] wkey_i,
  input  logic [31:0]   wword_i,
  input  logic [IW-1:0] raddr_i,
  output logic [KW-1:0] rkey_o,
  output logic [31:0]   rword_o
);

  logic [KW-1:0] key_mem  [DEPTH];
  logic [31:0]   word_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]  <= wkey_i;
      word_mem[waddr_i] <= wword_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o  <= key_mem[raddr_i];
    rword_o <= word_mem[raddr_i];
  end

endmodule

@@ sv/free_list_keyed_table.sv @@
// ----------------------------------------------------------------------------
// free_list_keyed_table: slot allocator with keyed search
// Add, delete and search over a slot table closed by a tail sentinel, with
// freed slots chained in a free list through their data words.
// ----------------------------------------------------------------------------
// An operation is taken when start_i is high and busy_o is low; its result is
// shown for exactly one cycle with done_o high and cannot be held off, so
// capture it on that cycle. After reset the block is busy while it writes
// the sentinel into slot 0. After S_DISPATCH, an add into a freed slot passes
// through S_LINK, any delete of a slot below the sentinel, used or already
// free, through S_DEL_CHK and an add that grows the table through S_GROW; an
// add to a full table, a delete with a bad index and an unused code end in
// S_DISPATCH. Search reads the key store one slot per cycle through its single
// read port and stops at the first matching slot or at the tail sentinel.
// ----------------------------------------------------------------------------
module free_list_keyed_table
  import fkt_pkg::*;
#(
  parameter int unsigned DEPTH     = FKT_DEPTH,
  parameter int unsigned KEY_BYTES = FKT_KEY_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] key_i,
  input  logic signed [31:0] value_i,
  input  logic [5:0]  slot_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [5:0]  where_o,
  output logic [6:0]  used_length_o,
  output logic [6:0]  free_count_o
);

  localparam int unsigned KW = 8 * KEY_BYTES;
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > 6) ? LW : 6;

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_LINK     = 3'd3;
  localparam logic [2:0] S_GROW     = 3'd4;
  localparam logic [2:0] S_DEL_CHK  = 3'd5;
  localparam logic [2:0] S_SCAN     = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] free_q, free_d;
  logic          done_q, done_d;
  logic [2:0]    status_q, status_d;
  logic [IW-1:0] where_q, where_d;
  logic [LW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;

  logic [1:0]    func_q;
  logic [KW-1:0] key_q;
  logic [31:0]   value_q;
  logic [5:0]    slot_q;

  logic [KW-1:0] norm_key;
  logic          accept;
  logic [LW-1:0] tail;
  logic [IW-1:0] tail_ix;
  logic [IW-1:0] slot_ix;
  logic          link_ok;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [KW-1:0] mem_wkey;
  logic [31:0]   mem_wword;
  logic [IW-1:0] mem_raddr;
  logic [KW-1:0] mem_rkey;
  logic [31:0]   mem_rword;

  fkt_key_norm #(
    .KEY_BYTES(KEY_BYTES)
  ) u_norm (
    .key_i(key_i),
    .key_o(norm_key)
  );

  fkt_slot_mem #(
    .DEPTH(DEPTH),
    .KW   (KW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wkey_i (mem_wkey),
    .wword_i(mem_wword),
    .raddr_i(mem_raddr),
    .rkey_o (mem_rkey),
    .rword_o(mem_rword)
  );

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign tail    = len_q - LW'(1);
  assign tail_ix = tail[IW-1:0];
  assign slot_ix = IW'(slot_q);
  assign link_ok = (mem_rword[31:IW] == '0) && (LW'(mem_rword[IW-1:0]) < tail);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    len_d     = len_q;
    free_d    = free_q;
    done_d    = 1'b0;
    status_d  = status_q;
    where_d   = where_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    mem_we    = 1'b0;
    mem_waddr = where_q;
    mem_wkey  = key_q;
    mem_wword = value_q;
    mem_raddr = rd_idx_q[IW-1:0];

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wkey  = '0;
        mem_wword = SENTINEL_WORD;
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (func_q)
          FUNC_ADD: begin
            if (LW'(head_q) >= tail) begin
              if (len_q >= LW'(DEPTH)) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
                where_d  = '0;
                state_d  = S_IDLE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_ix;
                where_d   = tail_ix;
                state_d   = S_GROW;
              end
            end else begin
              mem_raddr = head_q;
              where_d   = head_q;
              state_d   = S_LINK;
            end
          end
          FUNC_DELETE: begin
            if (CW'(slot_q) >= CW'(tail)) begin
              done_d   = 1'b1;
              status_d = ST_BAD_INDEX;
              where_d  = '0;
              state_d  = S_IDLE;
            end else begin
              mem_raddr = slot_ix;
              state_d   = S_DEL_CHK;
            end
          end
          FUNC_SEARCH: begin
            mem_raddr = '0;
            rd_idx_d  = LW'(1);
            cmp_idx_d = '0;
            state_d   = S_SCAN;
          end
          default: begin
            done_d   = 1'b1;
            status_d = ST_OK;
            where_d  = '0;
            state_d  = S_IDLE;
          end
        endcase
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = where_q;
        head_d    = link_ok ? mem_rword[IW-1:0] : tail_ix;
        free_d    = free_q - LW'(1);
        done_d    = 1'b1;
        status_d  = ST_OK;
        state_d   = S_IDLE;
      end
      S_GROW: begin
        mem_we    = 1'b1;
        mem_waddr = where_q + IW'(1);
        mem_wkey  = '0;
        mem_wword = SENTINEL_WORD;
        len_d     = len_q + LW'(1);
        head_d    = where_q + IW'(1);
        free_d    = LW'(1);
        done_d    = 1'b1;
        status_d  = ST_OK;
        state_d   = S_IDLE;
      end
      S_DEL_CHK: begin
        done_d   = 1'b1;
        where_d  = '0;
        state_d  = S_IDLE;
        if (mem_rkey[KW-1 -: 8] == 8'd0) begin
          status_d = ST_ALREADY_FREE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = slot_ix;
          mem_wkey  = '0;
          mem_wword = 32'(head_q);
          head_d    = slot_ix;
          free_d    = free_q + LW'(1);
          status_d  = ST_OK;
        end
      end
      S_SCAN: begin
        mem_raddr = rd_idx_q[IW-1:0];
        rd_idx_d  = rd_idx_q + LW'(1);
        cmp_idx_d = rd_idx_q[IW-1:0];
        if (mem_rkey == key_q) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          where_d  = cmp_idx_q;
          state_d  = S_IDLE;
        end else if (LW'(cmp_idx_q) == tail) begin
          done_d   = 1'b1;
          status_d = ST_NOT_FOUND;
          where_d  = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      head_q    <= '0;
      len_q     <= LW'(1);
      free_q    <= LW'(1);
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      where_q   <= '0;
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      len_q     <= len_d;
      free_q    <= free_d;
      done_q    <= done_d;
      status_q  <= status_d;
      where_q   <= where_d;
      rd_idx_q  <= rd_idx_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      key_q   <= norm_key;
      value_q <= value_i;
      slot_q  <= slot_i;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign where_o       = 6'(where_q);
  assign used_length_o = 7'(len_q);
  assign free_count_o  = 7'(free_q);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("transfer did not raise busy");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("more than one result for one transfer");

  a_full_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> (len_q == LW'(DEPTH)))
    else $error("full reported below depth");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("slot write during search");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for free_list_keyed_table
// Drives add, delete and search commands with random idle gaps and checks
// every result strobe against a cycle-free model of the slot table, its free
// list and its key normalization. A directed part covers the corner cases
// and weighted random traffic then fills, churns, drains and refills the table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fkt_pkg::*;

  localparam int unsigned DEPTH       = FKT_DEPTH;
  localparam int unsigned KB          = FKT_KEY_BYTES;
  localparam logic [1:0]  FUNC_NOP    = 2'd3;
  localparam int          CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] where;
    logic [6:0] used_length;
    logic [6:0] free_count;
  } table_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  func_i;
  logic [63:0] key_i;
  logic signed [31:0] value_i;
  logic [5:0]  slot_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [5:0]  where_o;
  logic [6:0]  used_length_o;
  logic [6:0]  free_count_o;

  logic [63:0] tbl_key [DEPTH];
  logic [31:0] tbl_word[DEPTH];
  int unsigned tbl_head;
  int unsigned tbl_len;
  int unsigned tbl_free;

  table_result_t expected_results[$];
  int fail_count;
  int results_checked;
  int cycle_count;
  int op_count[4];
  int status_hits[5];

  free_list_keyed_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .slot_i        (slot_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .where_o       (where_o),
    .used_length_o (used_length_o),
    .free_count_o  (free_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           expected_results.size());
    $display("status: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Table model
  // -------------------------------------------------------------------------
  function automatic logic [63:0] clean_key(input logic [63:0] k);
    logic [63:0] r;
    logic        ended;
    logic [7:0]  b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < KB; i++) begin
      b = k[8*(KB-1-i) +: 8];
      if (b == 8'h00) ended = 1'b1;
      if (!ended) r[8*(KB-1-i) +: 8] = b;
    end
    return r;
  endfunction

  function automatic logic [7:0] first_byte(input logic [63:0] k);
    return k[8*(KB-1) +: 8];
  endfunction

  task automatic reset_table();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_key[i]  = '0;
      tbl_word[i] = '0;
    end
    tbl_word[0] = SENTINEL_WORD;
    tbl_head    = 0;
    tbl_len     = 1;
    tbl_free    = 1;
  endtask

  task automatic apply_op(input logic [1:0] f, input logic [63:0] k_raw,
                          input logic [31:0] v, input logic [5:0] s,
                          output table_result_t r);
    logic [63:0] k;
    logic [31:0] lnk;
    int unsigned tail;
    int unsigned h;
    k        = clean_key(k_raw);
    tail     = tbl_len - 1;
    r.status = ST_OK;
    r.where  = '0;
    case (f)
      FUNC_ADD: begin
        h = tbl_head;
        if (h >= tail) begin
          if (tbl_len >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tbl_key[tail]      = k;
            tbl_word[tail]     = v;
            r.where            = tail[5:0];
            tbl_len            = tail + 2;
            tbl_head           = tail + 1;
            tbl_free           = 1;
            tbl_key[tail + 1]  = '0;
            tbl_word[tail + 1] = SENTINEL_WORD;
          end
        end else begin
          lnk         = tbl_word[h];
          tbl_head    = (lnk < tail) ? lnk : tail;
          tbl_free    = tbl_free - 1;
          tbl_key[h]  = k;
          tbl_word[h] = v;
          r.where     = h[5:0];
        end
      end
      FUNC_DELETE: begin
        if (s >= tail) begin
          r.status = ST_BAD_INDEX;
        end else if (first_byte(tbl_key[s]) == 8'h00) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          tbl_key[s]  = '0;
          tbl_word[s] = tbl_head;
          tbl_head    = s;
          tbl_free    = tbl_free + 1;
        end
      end
      FUNC_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < tbl_len && i < DEPTH; i++) begin
          if (tbl_key[i] == k) begin
            r.status = ST_OK;
            r.where  = i[5:0];
            break;
          end
        end
      end
      default: ;
    endcase
    r.used_length = tbl_len[6:0];
    r.free_count  = tbl_free[6:0];
  endtask

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("result strobe with no command outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (where_o !== want.where) begin
          $error("where mismatch: expected %0d, got %0d", want.where, where_o);
          fail_count++;
        end
        if (used_length_o !== want.used_length) begin
          $error("used_length mismatch: expected %0d, got %0d", want.used_length,
                 used_length_o);
          fail_count++;
        end
        if (free_count_o !== want.free_count) begin
          $error("free_count mismatch: expected %0d, got %0d", want.free_count,
                 free_count_o);
          fail_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Command driving
  // -------------------------------------------------------------------------
  task automatic issue_op(input logic [1:0] f, input logic [63:0] k,
                          input logic [31:0] v, input logic [5:0] s);
    table_result_t r;
    @(negedge clk_i);
    start_i = 1'b1;
    func_i  = f;
    key_i   = k;
    value_i = v;
    slot_i  = s;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_op(f, k, v, s, r);
    expected_results.push_back(r);
    op_count[f]++;
    status_hits[r.status]++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Half the time short names from a tiny alphabet so duplicates occur, else full
  // byte range; junk may follow the terminating zero byte.
  function automatic logic [63:0] make_name();
    logic [63:0] k;
    logic [7:0]  b;
    int          len;
    bit          tiny;
    k    = '0;
    tiny = $urandom_range(0, 1);
    len  = tiny ? $urandom_range(1, 2) : $urandom_range(1, KB);
    for (int i = 0; i < KB; i++) begin
      if (i < len) b = tiny ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom_range(1, 255));
      else if (i > len && $urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'h00;
      k[8*(KB-1-i) +: 8] = b;
    end
    return k;
  endfunction

  function automatic int pick_used_slot();
    int cand[$];
    for (int i = 0; i + 1 < tbl_len; i++)
      if (first_byte(tbl_key[i]) != 8'h00) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic run_traffic(input int n, input int add_w, input int del_w,
                             input int search_w);
    int          roll;
    int          pick;
    bit          burst;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < add_w) begin
        k = make_name();
        if ($urandom_range(0, 9) == 0) k[63:56] = 8'h00;
        issue_op(FUNC_ADD, k, $urandom, 6'($urandom_range(0, 63)));
      end else if (roll < add_w + del_w) begin
        pick = pick_used_slot();
        if (pick < 0 || $urandom_range(0, 99) < 15) pick = $urandom_range(0, 63);
        issue_op(FUNC_DELETE, make_name(), $urandom, 6'(pick));
      end else if (roll < add_w + del_w + search_w) begin
        roll = $urandom_range(0, 99);
        pick = pick_used_slot();
        if (roll < 60 && pick >= 0) begin
          k = tbl_key[pick];
          if (k[7:0] == 8'h00 && $urandom_range(0, 1) == 1) k[7:0] = 8'($urandom_range(1, 255));
        end else if (roll < 75) begin
          k = {8'h00, 32'($urandom), 24'($urandom)};
        end else begin
          k = make_name();
        end
        issue_op(FUNC_SEARCH, k, $urandom, 6'($urandom_range(0, 63)));
      end else begin
        issue_op(FUNC_NOP, {$urandom, $urandom}, $urandom, 6'($urandom_range(0, 63)));
      end
      if (!burst) idle_cycles(random_gap());
    end
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_add_paths();
    issue_op(FUNC_SEARCH, 64'h0, 32'h0, 6'd0);
    issue_op(FUNC_ADD, 64'h4100_0000_0000_0000, 32'h8000_0000, 6'd0);
    issue_op(FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 6'd63);
    issue_op(FUNC_ADD, 64'h4142_0000_DEAD_BEEF, 32'h0000_0000, 6'd0);
    issue_op(FUNC_ADD, 64'h00FF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
  endtask

  task automatic test_search_paths();
    issue_op(FUNC_SEARCH, 64'h4142_00FF_0000_0001, 32'h0, 6'd0);
    issue_op(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 6'd0);
    issue_op(FUNC_SEARCH, 64'h0000_0000_0000_0000, 32'h0, 6'd0);
    issue_op(FUNC_SEARCH, 64'h5A00_0000_0000_0000, 32'h0, 6'd0);
  endtask

  task automatic test_delete_paths();
    issue_op(FUNC_DELETE, 64'h0, 32'h0, 6'd4);
    issue_op(FUNC_DELETE, 64'h0, 32'h0, 6'd63);
    issue_op(FUNC_DELETE, 64'h0, 32'h0, 6'd3);
    issue_op(FUNC_DELETE, 64'h0, 32'h0, 6'd1);
    issue_op(FUNC_DELETE, 64'h0, 32'h0, 6'd1);
    issue_op(FUNC_SEARCH, 64'h0, 32'h0, 6'd0);
  endtask

  task automatic test_free_reuse();
    issue_op(FUNC_DELETE, 64'h0, 32'h0, 6'd0);
    issue_op(FUNC_ADD, 64'h4200_0000_0000_0000, 32'h1234_5678, 6'd0);
    issue_op(FUNC_ADD, 64'h4300_0000_0000_0000, 32'hA5A5_A5A5, 6'd0);
    issue_op(FUNC_ADD, 64'h4445_4647_4849_4A4B, 32'h5A5A_5A5A, 6'd0);
    issue_op(FUNC_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    issue_op(FUNC_ADD, 64'h0, 32'h0, 6'd0);
  endtask

  task automatic test_fill_table();
    run_traffic(300, 85, 5, 8);
  endtask

  task automatic test_mixed_traffic();
    run_traffic(800, 40, 25, 30);
  endtask

  task automatic test_drain_table();
    run_traffic(250, 15, 65, 15);
  endtask

  task automatic test_refill_table();
    run_traffic(350, 70, 10, 17);
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    func_i          = FUNC_ADD;
    key_i           = '0;
    value_i         = '0;
    slot_i          = '0;
    fail_count      = 0;
    results_checked = 0;
    cycle_count     = 0;
    op_count        = '{default: 0};
    status_hits     = '{default: 0};
    reset_table();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_add_paths();
    test_search_paths();
    test_delete_paths();
    test_free_reuse();
    wait_for_results();
    test_fill_table();
    test_mixed_traffic();
    wait_for_results();
    test_drain_table();
    idle_cycles(1);
    test_refill_table();

    wait_for_results();
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("ran %0d adds, %0d deletes, %0d searches, %0d no-ops; %0d results checked",
             op_count[FUNC_ADD], op_count[FUNC_DELETE], op_count[FUNC_SEARCH],
             op_count[FUNC_NOP], results_checked);
    $display("outcomes: %0d ok, %0d already free, %0d full, %0d bad index, %0d not found",
             status_hits[ST_OK], status_hits[ST_ALREADY_FREE], status_hits[ST_FULL],
             status_hits[ST_BAD_INDEX], status_hits[ST_NOT_FOUND]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
